@@ hw/rtl/binary_to_bcd_digit_strobe_defines.svh @@
// Assertion macros shared by the binary to BCD digit strobe checkers.
// No dependencies; include by bare file name.
`ifndef BINARY_TO_BCD_DIGIT_STROBE_DEFINES_SVH
`define BINARY_TO_BCD_DIGIT_STROBE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define B2BCD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define B2BCD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/b2bcd_pkg.sv @@
// Shared constants, types and helpers for the binary to BCD digit strobe.
// No dependencies.
package b2bcd_pkg;

    localparam int MAX_DIGITS  = 3;
    localparam int VALUE_WIDTH = 32;

    localparam int DIGIT_W  = 4;
    localparam int SEL_W    = 2;
    localparam int CNT_W    = $clog2(MAX_DIGITS + 1);
    localparam int CFG_W    = 2;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 8;
    localparam int VEC_W    = MAX_DIGITS * DIGIT_W;

    // Reciprocal of ten for a 32-bit dividend: q = (x * DIV10_MUL) >> DIV10_SHIFT
    localparam int          PROD_W      = VALUE_WIDTH + 32;
    localparam logic [31:0] DIV10_MUL   = 32'hCCCC_CCCD;
    localparam int          DIV10_SHIFT = 35;

    localparam logic [CFG_W-1:0] COUNT_RESET = CFG_W'(3);

    typedef logic [DIGIT_W-1:0]           digit_t;
    typedef logic [MAX_DIGITS-1:0][DIGIT_W-1:0] digit_vec_t;
    typedef logic [CNT_W-1:0]             count_t;
    typedef logic [VALUE_WIDTH-1:0]       quot_t;

    // Item as it travels down the divide-by-ten pipeline
    typedef struct packed {
        quot_t      quot;
        digit_vec_t digits;
        count_t     count;
    } stage_data_t;

    // Low four bits of ten times q
    function automatic digit_t times10_lo(input quot_t q);
        digit_t a;
        digit_t b;
        a = {q[0], 3'b000};
        b = {q[2:0], 1'b0};
        return digit_t'(a + b);
    endfunction

endpackage

@@ hw/rtl/binary_to_bcd_digit_strobe.sv @@
// Binary to BCD digit strobe. Each 32-bit value on the input stream is
// reduced to its lowest digit_count decimal digits (digit_count 0..3, reset 3),
// which leave one per output item, most significant first, with the select
// line index counting from 0 and tlast on the final digit; a count of zero
// sends nothing. A value passes through the divide-by-ten pipeline, one
// stage per digit, then into the output register. The pipeline takes a value
// every cycle unless the output stalls it; the serializer sends one digit per
// cycle while m_tready is high, loads the next value as the final digit is
// taken, and passes zero-count values at one per cycle. Write digit_count only
// while idle. Depends on b2bcd_pkg, b2bcd_div_stage and b2bcd_serializer.
module binary_to_bcd_digit_strobe (
    input  logic                            aclk,
    input  logic                            aresetn,
    // cfg_data: digit_count[1:0]
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [b2bcd_pkg::CFG_W-1:0]     cfg_data,
    // s_tdata: value[31:0]
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [b2bcd_pkg::S_DATA_W-1:0]  s_tdata,
    // m_tdata: digit[3:0], select_index[5:4], zero[7:6]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [b2bcd_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                            m_tlast
);

    localparam int N = b2bcd_pkg::MAX_DIGITS;

    logic [b2bcd_pkg::CFG_W-1:0] digit_count_reg;
    b2bcd_pkg::count_t           count_clamped;
    logic                        stg_valid [N+1];
    logic                        stg_ready [N+1];
    b2bcd_pkg::stage_data_t      stg_data  [N+1];

    // Configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digit_count_reg <= b2bcd_pkg::COUNT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            digit_count_reg <= cfg_data;
        end
    end

    // Saturate the count at the number of digit slots
    assign count_clamped = (32'(digit_count_reg) > N) ? b2bcd_pkg::count_t'(N)
                                                      : b2bcd_pkg::count_t'(digit_count_reg);

    // Pipeline entry
    assign stg_valid[0]       = s_tvalid;
    assign s_tready           = stg_ready[0];
    assign stg_data[0].quot   = b2bcd_pkg::quot_t'(s_tdata[b2bcd_pkg::VALUE_WIDTH-1:0]);
    assign stg_data[0].digits = '0;
    assign stg_data[0].count  = count_clamped;

    // One divide-by-ten stage per digit slot
    for (genvar k = 0; k < N; k++) begin : g_stage
        b2bcd_div_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stg_valid[k]),
            .in_ready  (stg_ready[k]),
            .in_data   (stg_data[k]),
            .out_valid (stg_valid[k+1]),
            .out_ready (stg_ready[k+1]),
            .out_data  (stg_data[k+1])
        );
    end

    b2bcd_serializer u_ser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (stg_valid[N]),
        .in_ready (stg_ready[N]),
        .in_data  (stg_data[N]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

@@ hw/rtl/b2bcd_div_stage.sv @@
// One divide-by-ten pipeline stage: peels off the lowest decimal digit.
// Depends on b2bcd_pkg.
module b2bcd_div_stage (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  b2bcd_pkg::stage_data_t in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output b2bcd_pkg::stage_data_t out_data
);

    logic                    valid_reg;
    b2bcd_pkg::stage_data_t  data_reg;
    b2bcd_pkg::stage_data_t  data_next;
    logic [b2bcd_pkg::PROD_W-1:0] prod;
    b2bcd_pkg::quot_t        quot;
    b2bcd_pkg::digit_t       digit;

    // Advance when the slot is empty or its item moves on
    assign in_ready = !valid_reg || out_ready;

    // Divide by ten through the reciprocal, remainder from the low bits;
    // the new digit enters the top slot and earlier digits move down
    always_comb begin
        prod  = b2bcd_pkg::PROD_W'(in_data.quot) * b2bcd_pkg::PROD_W'(b2bcd_pkg::DIV10_MUL);
        quot  = b2bcd_pkg::quot_t'(prod >> b2bcd_pkg::DIV10_SHIFT);
        digit = b2bcd_pkg::digit_t'(in_data.quot[3:0] - b2bcd_pkg::times10_lo(quot));
        data_next.quot   = quot;
        data_next.digits = {digit, in_data.digits[b2bcd_pkg::MAX_DIGITS-1:1]};
        data_next.count  = in_data.count;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // Payload, no reset
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ hw/rtl/b2bcd_serializer.sv @@
// Output serializer: sends the kept digits of one item, most significant first.
// Depends on b2bcd_pkg.
module b2bcd_serializer (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  b2bcd_pkg::stage_data_t         in_data,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [b2bcd_pkg::M_DATA_W-1:0] m_tdata,
    output logic                           m_tlast
);

    logic                            busy_reg;
    logic                            busy_next;
    logic [b2bcd_pkg::VEC_W-1:0]     digits_reg;
    logic [b2bcd_pkg::VEC_W-1:0]     digits_next;
    b2bcd_pkg::count_t               left_reg;
    b2bcd_pkg::count_t               left_next;
    logic [b2bcd_pkg::SEL_W-1:0]     sel_reg;
    logic [b2bcd_pkg::SEL_W-1:0]     sel_next;
    b2bcd_pkg::count_t               skip;
    logic                            take;
    logic                            final_digit;

    assign final_digit = (left_reg == b2bcd_pkg::count_t'(1));
    assign take        = busy_reg && m_tready;
    assign in_ready    = !busy_reg || (m_tready && final_digit);
    assign skip        = b2bcd_pkg::count_t'(b2bcd_pkg::MAX_DIGITS) - in_data.count;

    // Load a new item, or drop the digit just taken
    always_comb begin
        busy_next   = busy_reg;
        digits_next = digits_reg;
        left_next   = left_reg;
        sel_next    = sel_reg;
        if (in_valid && in_ready) begin
            busy_next   = (in_data.count != '0);
            digits_next = in_data.digits << {skip, 2'b00};
            left_next   = in_data.count;
            sel_next    = '0;
        end else if (take) begin
            busy_next   = !final_digit;
            digits_next = digits_reg << b2bcd_pkg::DIGIT_W;
            left_next   = b2bcd_pkg::count_t'(left_reg - b2bcd_pkg::count_t'(1));
            sel_next    = b2bcd_pkg::SEL_W'(sel_reg + b2bcd_pkg::SEL_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            left_reg <= '0;
            sel_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            left_reg <= left_next;
            sel_reg  <= sel_next;
        end
    end

    always_ff @(posedge aclk) begin
        digits_reg <= digits_next;
    end

    // Most significant remaining digit sits in the top slot
    assign m_tvalid = busy_reg;
    assign m_tlast  = final_digit;
    assign m_tdata  = {2'b00, sel_reg,
                       digits_reg[b2bcd_pkg::VEC_W-1 -: b2bcd_pkg::DIGIT_W]};

endmodule

@@ hw/rtl/b2bcd_checker.sv @@
// Port-level checks on the digit stream of binary_to_bcd_digit_strobe.
// Depends on binary_to_bcd_digit_strobe_defines.svh; bound to the top level below.
`include "binary_to_bcd_digit_strobe_defines.svh"

module b2bcd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // Hold a stalled item
    `B2BCD_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled digit changed")

    // Digit is decimal and padding is zero
    `B2BCD_ASSERT_NOW(a_bcd, aclk, aresetn, m_tvalid, (m_tdata[3:0] <= 4'd9) && (m_tdata[7:6] == 2'b00), "bad BCD code or padding")

    // Select index three never appears; the third digit always closes the value
    `B2BCD_ASSERT_NOW(a_sel_last, aclk, aresetn, m_tvalid && (m_tdata[5:4] != 2'd0) && (m_tdata[5:4] != 2'd1), (m_tdata[5:4] == 2'd2) && m_tlast, "select index out of range")

    // A taken non-final digit is followed straight away by the next select line
    `B2BCD_ASSERT_NEXT(a_sel_step, aclk, aresetn, m_tvalid && m_tready && !m_tlast, m_tvalid && (m_tdata[5:4] == 2'($past(m_tdata[5:4]) + 2'd1)), "select index did not step")

endmodule

bind binary_to_bcd_digit_strobe b2bcd_checker u_b2bcd_checker (.*);

@@ tb/tb.sv @@
// Self-checking testbench for binary_to_bcd_digit_strobe: directed table, then random phases.
// Depends on b2bcd_pkg and the binary_to_bcd_digit_strobe RTL; reads no files.
`timescale 1ns / 1ps

module tb;

    localparam int PIPE_SETTLE  = 16;
    localparam int DRAIN_LIMIT  = 4000;
    localparam int REPORT_LIMIT = 10;
    localparam int N_DIRECTED   = 22;
    localparam int N_PHASES     = 8;
    localparam int PHASE_ITEMS  = 30;

    // One digit strobe as it should leave the block
    typedef struct packed {
        logic [b2bcd_pkg::DIGIT_W-1:0] bcd;
        logic [b2bcd_pkg::SEL_W-1:0]   sel;
        logic                          last;
    } digit_strobe_t;

    // Directed row: count to show, value, and the shown digits where typed in
    typedef struct packed {
        logic [b2bcd_pkg::CFG_W-1:0] count;
        logic [31:0]                 value;
        logic                        typed;
        logic [11:0]                 shown;
    } stim_row_t;

    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        '{2'd3, 32'd0,          1'b1, 12'h000},
        '{2'd3, 32'hFFFF_FFFF,  1'b1, 12'h295},
        '{2'd3, 32'd999,        1'b1, 12'h999},
        '{2'd3, 32'd1000,       1'b1, 12'h000},
        '{2'd3, 32'd1,          1'b1, 12'h001},
        '{2'd3, 32'd10,         1'b1, 12'h010},
        '{2'd3, 32'd123456789,  1'b1, 12'h789},
        '{2'd3, 32'h8000_0000,  1'b1, 12'h648},
        '{2'd3, 32'h5555_5555,  1'b0, 12'h000},
        '{2'd3, 32'hAAAA_AAAA,  1'b0, 12'h000},
        '{2'd1, 32'd0,          1'b1, 12'h000},
        '{2'd1, 32'd9,          1'b1, 12'h009},
        '{2'd1, 32'hFFFF_FFFF,  1'b1, 12'h005},
        '{2'd1, 32'h1234_5678,  1'b0, 12'h000},
        '{2'd2, 32'd99,         1'b1, 12'h099},
        '{2'd2, 32'd100,        1'b1, 12'h000},
        '{2'd2, 32'hFFFF_FFFF,  1'b1, 12'h095},
        '{2'd2, 32'hDEAD_BEEF,  1'b0, 12'h000},
        '{2'd0, 32'hFFFF_FFFF,  1'b1, 12'h000},
        '{2'd0, 32'd0,          1'b1, 12'h000},
        '{2'd0, 32'd12345,      1'b1, 12'h000},
        '{2'd3, 32'd7,          1'b1, 12'h007}
    };

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [b2bcd_pkg::CFG_W-1:0]    cfg_data  = '0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [b2bcd_pkg::S_DATA_W-1:0] s_tdata   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [b2bcd_pkg::M_DATA_W-1:0] m_tdata;
    logic                           m_tlast;

    digit_strobe_t digits_due[$];
    logic [b2bcd_pkg::CFG_W-1:0] shown_count = b2bcd_pkg::COUNT_RESET;
    bit  steady = 1'b0;
    int  mismatches = 0;
    int  values_sent = 0;
    int  digits_seen = 0;
    bit  [3:0] counts_used = 4'b0;

    binary_to_bcd_digit_strobe u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),   // digit_count[1:0]
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // value[31:0]
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // digit[3:0], select_index[5:4], zero[7:6]
        .m_tlast   (m_tlast)
    );

    always #5 aclk = ~aclk;

    function automatic void flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    // Split a value into its shown decimal digits, most significant first
    function automatic void queue_digits(input logic [31:0] value,
                                         input logic [b2bcd_pkg::CFG_W-1:0] count);
        logic [31:0]                   rest;
        logic [b2bcd_pkg::DIGIT_W-1:0] lane [b2bcd_pkg::MAX_DIGITS];
        int                            n;
        digit_strobe_t                 d;
        n = (int'(count) > b2bcd_pkg::MAX_DIGITS) ? b2bcd_pkg::MAX_DIGITS : int'(count);
        rest = value;
        for (int i = 0; i < n; i++) begin
            lane[n - 1 - i] = b2bcd_pkg::DIGIT_W'(rest % 10);
            rest = rest / 10;
        end
        for (int i = 0; i < n; i++) begin
            d.bcd  = lane[i];
            d.sel  = b2bcd_pkg::SEL_W'(i);
            d.last = (i == n - 1);
            digits_due.push_back(d);
        end
    endfunction

    // Digits read straight off a directed row, lowest nibbles kept
    function automatic void queue_typed(input logic [11:0] shown,
                                        input logic [b2bcd_pkg::CFG_W-1:0] count);
        digit_strobe_t d;
        int            n;
        n = int'(count);
        for (int i = 0; i < n; i++) begin
            d.bcd  = shown[(n - 1 - i) * 4 +: 4];
            d.sel  = b2bcd_pkg::SEL_W'(i);
            d.last = (i == n - 1);
            digits_due.push_back(d);
        end
    endfunction

    // Drop valid, wait for every pending digit, then let the pipeline empty
    task automatic settle_idle();
        int spin;
        spin = 0;
        s_tvalid <= 1'b0;
        while (digits_due.size() != 0 && spin < DRAIN_LIMIT) begin
            @(posedge aclk);
            spin++;
        end
        if (digits_due.size() != 0) begin
            flag_mismatch($sformatf("%0d digits never arrived", digits_due.size()));
            digits_due.delete();
        end
        repeat (PIPE_SETTLE) @(posedge aclk);
    endtask

    // Write digit_count once the block is idle
    task automatic write_count(input logic [b2bcd_pkg::CFG_W-1:0] count);
        settle_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= count;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        shown_count = count;
    endtask

    // Offer one value, with an occasional gap before it
    task automatic send_value(input logic [31:0] value, input logic typed,
                              input logic [11:0] shown);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(0, 99) < 24)
            gap = $urandom_range(1, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        if (typed)
            queue_typed(shown, shown_count);
        else
            queue_digits(value, shown_count);
        counts_used[shown_count] = 1'b1;
        values_sent++;
    endtask

    // Random value biased towards decimal boundaries and bit extremes
    function automatic logic [31:0] pick_value();
        logic [31:0] p;
        int          k;
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 999);
            1: begin
                k = $urandom_range(1, 9);
                p = 1;
                for (int i = 0; i < k; i++) p = p * 10;
                return p + 32'($urandom_range(0, 2)) - 32'd1;
            end
            2: return ~(32'd1 << $urandom_range(0, 31));
            3: return 32'd1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // Randomly stall the result side, except in the steady stretch
    always @(posedge aclk)
        m_tready <= steady || ($urandom_range(0, 99) >= 24);

    // Check each accepted digit against the oldest pending one
    always @(posedge aclk) begin
        digit_strobe_t want;
        if (aresetn && m_tvalid && m_tready) begin
            digits_seen++;
            if (digits_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected digit tdata=%h tlast=%b", m_tdata, m_tlast));
            end else begin
                want = digits_due.pop_front();
                if (m_tdata[3:0] != want.bcd || m_tdata[5:4] != want.sel
                        || m_tlast != want.last || m_tdata[7:6] != 2'b00)
                    flag_mismatch($sformatf(
                        "digit exp bcd=%0d sel=%0d last=%b, got bcd=%0d sel=%0d last=%b pad=%b",
                        want.bcd, want.sel, want.last,
                        m_tdata[3:0], m_tdata[5:4], m_tlast, m_tdata[7:6]));
            end
        end
    end

    initial begin
        logic [b2bcd_pkg::CFG_W-1:0] phase_count [N_PHASES];
        phase_count = '{2'd1, 2'd3, 2'd0, 2'd2, 2'd3, 2'd2, 2'd1, 2'd3};

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Walk the directed table, rewriting the count where a row asks for another
        for (int r = 0; r < N_DIRECTED; r++) begin
            if (DIRECTED[r].count != shown_count)
                write_count(DIRECTED[r].count);
            send_value(DIRECTED[r].value, DIRECTED[r].typed, DIRECTED[r].shown);
        end

        // Random phases, one count each; one phase runs with no idling at all
        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_count(phase_count[ph]);
            steady = (ph == 4);
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_value(pick_value(), 1'b0, 12'h000);
            steady = 1'b0;
        end

        settle_idle();
        $display("Sent %0d values, checked %0d digits, digit counts used (3..0): %b",
                 values_sent, digits_seen, counts_used);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0)
            $display("** binary_to_bcd_digit_strobe: PASSED **");
        else
            $display("** binary_to_bcd_digit_strobe: FAILED **");
        $finish;
    end

    // Hard stop should the handshakes hang
    initial begin
        #2_000_000;
        $display("Timeout with %0d digits pending", digits_due.size());
        $display("** binary_to_bcd_digit_strobe: FAILED **");
        $finish;
    end

endmodule
